### hdl/smr_pkg.sv
// Package for the saturation mixing ratio pipeline: widths, item types, coefficients.
package smr_pkg;

  // Field widths
  localparam int PRESS_W  = 17;
  localparam int TEMP_W   = 17;
  localparam int RATIO_W  = 32;
  localparam int VP_W     = 22;
  localparam int STATUS_W = 2;

  // Fixed-point formats
  localparam int RATIO_FRAC_BITS = 24;
  localparam int TEMP_FRAC_BITS  = 8;
  localparam int XFRAC           = 16;

  // Celsius temperature, clamped to [-80, 128] with XFRAC fraction bits
  localparam int X_W    = 25;
  // Horner accumulator and product widths
  localparam int ACC_W  = 38;
  localparam int PROD_W = X_W + ACC_W;

  // Horner chain: one cell per coefficient below the leading one
  localparam int HORNER_CELLS = 8;
  localparam int HIDX_W       = $clog2(HORNER_CELLS);
  localparam int SHIFT_W      = 5;

  // Ratio divider: integer bits, then fraction bits plus one rounding bit
  localparam int IPW = RATIO_W - RATIO_FRAC_BITS;
  localparam int QW  = IPW + RATIO_FRAC_BITS + 1;

  // Mixing ratio operand widths
  localparam int ES_W  = ACC_W - 1;
  localparam int PQ_W  = PRESS_W + XFRAC;
  localparam int NUM_W = ES_W + 10;
  localparam int DEN_W = PQ_W + 10;
  localparam int CMP_W = NUM_W + DEN_W;

  localparam logic [VP_W-1:0]    VP_MAX    = '1;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_LOW_PRESSURE = 2'd1,
    STATUS_SATURATED    = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRESS_W-1:0] pressure;
    logic [TEMP_W-1:0]  temperature;
  } in_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0]  mixing_ratio;
    logic [VP_W-1:0]     vapor_pressure;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Data handed from one Horner cell to the next
  typedef struct packed {
    logic                     valid;
    logic [PRESS_W-1:0]       pressure;
    logic signed [X_W-1:0]    x;
    logic signed [ACC_W-1:0]  acc;
  } horner_stage_t;

  // Data handed from one divider cell to the next
  typedef struct packed {
    logic               valid;
    logic [VP_W-1:0]    vp;
    logic               low_press;
    logic               ovf;
    logic [DEN_W-1:0]   den;
    logic [DEN_W-1:0]   rem;
    logic [QW-1:0]      word;
  } div_stage_t;

  // round(mant * 2^frac / 10^exp10), ties up, with sign; elaboration only
  function automatic logic signed [ACC_W-1:0] coef_fixed(input logic [22:0] mant,
                                                         input int unsigned exp10,
                                                         input int unsigned frac,
                                                         input logic neg);
    logic [127:0] n;
    logic [63:0]  v;
    n = 128'(mant) << (frac + 1);
    for (int i = 0; i < 24; i++) begin
      if (i < exp10) n = n / 128'd10;
    end
    v = (n[63:0] + 64'd1) >> 1;
    return neg ? -ACC_W'(v) : ACC_W'(v);
  endfunction

  // Leading coefficient c8 (negative), 80 fraction bits
  localparam logic signed [ACC_W-1:0] COEF_LEAD = coef_fixed(23'd3704404, 20, 80, 1'b1);

  // Coefficients c0..c7 at their stage formats
  localparam logic signed [ACC_W-1:0] COEF [HORNER_CELLS] = '{
    coef_fixed(23'd6105851, 4, 16, 1'b0),
    coef_fixed(23'd4440316, 5, 24, 1'b0),
    coef_fixed(23'd1430341, 6, 31, 1'b0),
    coef_fixed(23'd2641412, 8, 38, 1'b0),
    coef_fixed(23'd2995057, 10, 46, 1'b0),
    coef_fixed(23'd2031998, 12, 54, 1'b0),
    coef_fixed(23'd6936113, 15, 63, 1'b0),
    coef_fixed(23'd2564861, 18, 73, 1'b0)
  };

  // Rounding shift of stage k: 16 + F(k+1) - F(k)
  localparam logic [SHIFT_W-1:0] HSHIFT [HORNER_CELLS] = '{
    5'd24, 5'd23, 5'd23, 5'd24, 5'd24, 5'd25, 5'd26, 5'd23
  };

endpackage

### hdl/smr_horner_cell.sv
// One Horner step: multiply by x, round-shift, add the stage coefficient.
module smr_horner_cell import smr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [HIDX_W-1:0] idx,
  input  horner_stage_t     stage_in,
  output horner_stage_t     stage_out
);

  typedef struct packed {
    logic                     valid;
    logic [PRESS_W-1:0]       pressure;
    logic signed [X_W-1:0]    x;
    logic signed [PROD_W-1:0] prod;
  } horner_prod_t;

  horner_prod_t             prod_reg;
  horner_stage_t            stage_next;
  logic [SHIFT_W-1:0]       sh;
  logic signed [PROD_W-1:0] half;
  logic signed [PROD_W-1:0] rnd;

  // Product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod_reg.pressure <= stage_in.pressure;
      prod_reg.x        <= stage_in.x;
      prod_reg.prod     <= $signed(stage_in.x) * $signed(stage_in.acc);
    end
    if (rst) prod_reg.valid <= 1'b0;
    else if (en) prod_reg.valid <= stage_in.valid;
  end

  // Round to the next stage format and add coefficient
  always_comb begin
    sh                  = HSHIFT[idx];
    half                = PROD_W'(1) <<< (sh - SHIFT_W'(1));
    rnd                 = prod_reg.prod + half;
    stage_next.valid    = prod_reg.valid;
    stage_next.pressure = prod_reg.pressure;
    stage_next.x        = prod_reg.x;
    stage_next.acc      = COEF[idx] + ACC_W'(rnd >>> sh);
  end

  always_ff @(posedge clk) begin
    if (rst) stage_out.valid <= 1'b0;
    else if (en) stage_out <= stage_next;
  end

endmodule

### hdl/smr_div_cell.sv
// One restoring-division step: shift in a dividend bit, trial subtract, emit a quotient bit.
module smr_div_cell import smr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_stage_t stage_in,
  output div_stage_t stage_out
);

  div_stage_t       stage_next;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Trial subtract; the word shifts dividend bits out and quotient bits in
  always_comb begin
    rem_sh           = {stage_in.rem, stage_in.word[QW-1]};
    diff             = rem_sh - {1'b0, stage_in.den};
    ge               = rem_sh >= {1'b0, stage_in.den};
    stage_next       = stage_in;
    stage_next.rem   = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    stage_next.word  = {stage_in.word[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) stage_out.valid <= 1'b0;
    else if (en) stage_out <= stage_next;
  end

endmodule

### hdl/saturation_mixing_ratio.sv
// Saturation mixing ratio: Horner cell chain for vapor pressure, divider cell chain for ratio.
// Stages: 1 front, 8 Horner cells of 2 stages, 3 ratio setup stages, 33 divider cells,
//   1 output register.
// Throughput: one item per cycle while the skid entry is empty; every stage is a single register wide.
// Backpressure: a two-entry output buffer; the chain halts only while its skid entry is full.
// Reset (rst, synchronous): clears all stage valids and the output buffer; no other state.
module saturation_mixing_ratio import smr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int XSHIFT  = XFRAC - TEMP_FRAC_BITS;
  localparam int XRAW_W  = TEMP_W + XFRAC + 1;
  localparam logic signed [XRAW_W-1:0] K_OFFSET =
    XRAW_W'(((64'd27316 << XFRAC) + 64'd50) / 64'd100);
  localparam logic signed [XRAW_W-1:0] X_MIN = -XRAW_W'(80 << XFRAC);
  localparam logic signed [XRAW_W-1:0] X_MAX = XRAW_W'(128 << XFRAC);

  typedef struct packed {
    logic              valid;
    logic [VP_W-1:0]   vp;
    logic              low_press;
    logic [ES_W-1:0]   es;
    logic [PQ_W-1:0]   diff;
  } es_stage_t;

  typedef struct packed {
    logic              valid;
    logic [VP_W-1:0]   vp;
    logic              low_press;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } frac_stage_t;

  logic                      en;
  logic signed [XRAW_W-1:0]  x_raw;
  logic signed [XRAW_W-1:0]  x_clamp;
  horner_stage_t             front;
  horner_stage_t             hchain [HORNER_CELLS+1];
  es_stage_t                 es_reg;
  es_stage_t                 es_next;
  frac_stage_t               frac_reg;
  div_stage_t                div_next;
  div_stage_t                dchain [QW+1];
  logic [ES_W:0]             vp_sum;
  logic [ES_W-12:0]          vp_full;
  logic [PQ_W-1:0]           pq;
  logic                      sat;
  logic [QW:0]               q_rnd;
  out_item_t                 result;
  logic                      skid_valid;
  out_item_t                 skid_data;

  // Chain moves whenever the skid entry is free
  assign en       = !skid_valid;
  assign in_ready = en;

  // Front stage: Celsius conversion and clamp
  always_comb begin
    x_raw = $signed(XRAW_W'(in_data.temperature) << XSHIFT) - K_OFFSET;
    priority if (x_raw < X_MIN) x_clamp = X_MIN;
    else if (x_raw > X_MAX)     x_clamp = X_MAX;
    else                        x_clamp = x_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front.pressure <= in_data.pressure;
      front.x        <= X_W'(x_clamp);
      front.acc      <= COEF_LEAD;
    end
    if (rst) front.valid <= 1'b0;
    else if (en) front.valid <= in_valid;
  end

  // Horner chain, highest coefficient first
  assign hchain[0] = front;

  for (genvar j = 0; j < HORNER_CELLS; j++) begin : g_horner
    smr_horner_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (HIDX_W'(HORNER_CELLS - 1 - j)),
      .stage_in  (hchain[j]),
      .stage_out (hchain[j+1])
    );
  end

  // Vapor pressure: clip negative, round to 1/16 Pa, compare with pressure
  always_comb begin
    es_next.valid     = hchain[HORNER_CELLS].valid;
    es_next.es        = hchain[HORNER_CELLS].acc[ACC_W-1] ? '0
                                                          : hchain[HORNER_CELLS].acc[ES_W-1:0];
    vp_sum            = (ES_W+1)'(es_next.es) + (ES_W+1)'(2048);
    vp_full           = vp_sum[ES_W:12];
    es_next.vp        = (vp_full > (ES_W-11)'(VP_MAX)) ? VP_MAX : vp_full[VP_W-1:0];
    pq                = {hchain[HORNER_CELLS].pressure, {XFRAC{1'b0}}};
    es_next.low_press = ES_W'(pq) <= es_next.es;
    es_next.diff      = pq - es_next.es[PQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) es_reg.valid <= 1'b0;
    else if (en) es_reg <= es_next;
  end

  // Numerator and denominator of the ratio
  always_ff @(posedge clk) begin
    if (en) begin
      frac_reg.vp        <= es_reg.vp;
      frac_reg.low_press <= es_reg.low_press;
      frac_reg.num       <= NUM_W'(es_reg.es) * NUM_W'(10'd622);
      frac_reg.den       <= DEN_W'(es_reg.diff) * DEN_W'(10'd1000);
    end
    if (rst) frac_reg.valid <= 1'b0;
    else if (en) frac_reg.valid <= es_reg.valid;
  end

  // Integer-part overflow check and divider seed
  always_comb begin
    div_next.valid     = frac_reg.valid;
    div_next.vp        = frac_reg.vp;
    div_next.low_press = frac_reg.low_press;
    div_next.ovf       = CMP_W'(frac_reg.num) >= (CMP_W'(frac_reg.den) << IPW);
    div_next.den       = frac_reg.den;
    div_next.rem       = DEN_W'(frac_reg.num >> IPW);
    div_next.word      = {frac_reg.num[IPW-1:0], {(RATIO_FRAC_BITS+1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) dchain[0].valid <= 1'b0;
    else if (en) dchain[0] <= div_next;
  end

  // Divider chain, one quotient bit per cell
  for (genvar j = 0; j < QW; j++) begin : g_div
    smr_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage_in  (dchain[j]),
      .stage_out (dchain[j+1])
    );
  end

  // Round the quotient, saturate, pick status
  always_comb begin
    q_rnd                 = (QW+1)'(dchain[QW].word) + (QW+1)'(1);
    sat                   = dchain[QW].ovf || (&dchain[QW].word);
    result.vapor_pressure = dchain[QW].vp;
    priority if (dchain[QW].low_press) begin
      result.mixing_ratio = '0;
      result.status       = STATUS_LOW_PRESSURE;
    end else if (sat) begin
      result.mixing_ratio = RATIO_MAX;
      result.status       = STATUS_SATURATED;
    end else begin
      result.mixing_ratio = q_rnd[RATIO_W:1];
      result.status       = STATUS_OK;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (!out_valid || out_ready) begin
        out_valid <= dchain[QW].valid;
        out_data  <= result;
      end else if (dchain[QW].valid) begin
        skid_valid <= 1'b1;
        skid_data  <= result;
      end
    end else if (out_ready) begin
      out_valid  <= 1'b1;
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end
  end

endmodule
